[src/smao_pkg.sv]
// Package for the stack machine core: action and status codes, fixed field
// widths and the sequencer state type. No dependencies.
`default_nettype none

package smao_pkg;

    localparam int OPERAND_W = 32;
    localparam int ACTION_W  = 3;
    localparam int STATUS_W  = 3;
    localparam int CHAR_W    = 7;
    localparam int CHAR_MAX  = 127;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_PUSH  = 3'd0;
    localparam t_action ACT_POP   = 3'd1;
    localparam t_action ACT_DIV   = 3'd2;
    localparam t_action ACT_MOD   = 3'd3;
    localparam t_action ACT_PCHAR = 3'd4;
    localparam t_action ACT_ROTL  = 3'd5;

    localparam t_status STS_OK      = 3'd0;
    localparam t_status STS_SHORT   = 3'd1;
    localparam t_status STS_DIVZERO = 3'd2;
    localparam t_status STS_RANGE   = 3'd3;
    localparam t_status STS_FULL    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_TOP,
        ST_RD_SEC,
        ST_LOAD,
        ST_DIV,
        ST_WRITE,
        ST_ROT,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[src/stack_machine_alu_ops_core.sv]
// Stack machine core: a ring-buffer stack in a single-port-read memory with
// a serial restoring divider under a small sequencer. Depends on smao_pkg.
`default_nettype none

//  Channel   Signals                                          Direction  Handshake
//  command   start, i_action, i_operand                       in         start & !busy
//  result    o_done, o_status, o_char_out, o_char_valid,      out        o_done strobe
//            o_top_value, o_depth
//
// Push, pop, pchar, no-op and a refused div or mod on a short stack pass through FIN
// and OUT to the result strobe; rotl on two or more entries first reads the top in
// RD_TOP and writes it below the bottom in ROT. Div and mod read both operands, load
// the divider, which retires one quotient bit per cycle, and write the result; a zero
// divisor ends them at LOAD. busy goes high once the transfer is registered and stays
// high through the cycle of o_done. Reset empties the stack; memory contents are not
// cleared. The receiver cannot stall: every result is shown for exactly one cycle.
module stack_machine_alu_ops_core #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [smao_pkg::ACTION_W-1:0]        i_action,
    input  wire logic signed [smao_pkg::OPERAND_W-1:0] i_operand,
    output logic                                      o_done,
    output logic [smao_pkg::STATUS_W-1:0]             o_status,
    output logic [smao_pkg::CHAR_W-1:0]               o_char_out,
    output logic                                      o_char_valid,
    output logic signed [VALUE_WIDTH-1:0]             o_top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0]          o_depth
);

    localparam int VW      = VALUE_WIDTH;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(VALUE_WIDTH);
    localparam int OPW     = smao_pkg::OPERAND_W;

    // Sequencer and stack control.
    smao_pkg::t_state  r_state, n_state;
    smao_pkg::t_action r_action, n_action;
    smao_pkg::t_status r_status, n_status;
    logic [DEPTH_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0]  r_base, n_base;

    // Divider datapath.
    logic [VW-1:0]    r_quo, n_quo;
    logic [VW-1:0]    r_rem, n_rem;
    logic [VW-1:0]    r_dvs, n_dvs;
    logic             r_neg_q, n_neg_q;
    logic             r_neg_r, n_neg_r;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Stack memory ports.
    logic [VW-1:0]     stack_mem [STACK_DEPTH];
    logic [VW-1:0]     r_rdata;
    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [VW-1:0]     w_wdata;

    // Combinational helpers.
    logic [VW:0]       w_shift;
    logic [VW+1:0]     w_trial;
    logic [VW-1:0]     w_res_mag;
    logic              w_res_neg;
    logic [ADDR_W-1:0] w_base_dec;
    logic              w_char_ok;

    // Ring position of the entry at offset off above the bottom.
    function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] base,
                                               input logic [DEPTH_W-1:0] off);
        logic [DEPTH_W:0] s;
        s = (DEPTH_W+1)'(base) + (DEPTH_W+1)'(off);
        if (s >= (DEPTH_W+1)'(STACK_DEPTH)) begin
            s = s - (DEPTH_W+1)'(STACK_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [VW-1:0] sext(input logic [OPW-1:0] op);
        logic [VW+OPW-1:0] t;
        t = {{VW{op[OPW-1]}}, op};
        return t[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] absval(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + VW'(1)) : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            stack_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= stack_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smao_pkg::ST_IDLE;
            r_count <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_status <= n_status;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_cnt    <= n_cnt;
    end

    assign w_base_dec = (r_base == '0) ? ADDR_W'(STACK_DEPTH - 1) : r_base - ADDR_W'(1);

    // One restoring division step: shift in the next dividend bit, try the subtract.
    assign w_shift = {r_rem, r_quo[VW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};

    assign w_res_mag = (r_action == smao_pkg::ACT_DIV) ? r_quo : r_rem;
    assign w_res_neg = (r_action == smao_pkg::ACT_DIV) ? r_neg_q : r_neg_r;

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_status = r_status;
        n_count  = r_count;
        n_base   = r_base;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_neg_q  = r_neg_q;
        n_neg_r  = r_neg_r;
        n_cnt    = r_cnt;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_waddr  = '0;
        w_raddr  = '0;
        w_wdata  = '0;

        unique case (r_state)
            smao_pkg::ST_IDLE: begin
                if (start) begin
                    n_action = i_action;
                    n_status = smao_pkg::STS_OK;
                    n_state  = smao_pkg::ST_FIN;
                    unique case (i_action)
                        smao_pkg::ACT_PUSH: begin
                            if (r_count >= DEPTH_W'(STACK_DEPTH)) begin
                                n_status = smao_pkg::STS_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = slot(r_base, r_count);
                                w_wdata = sext(i_operand);
                                n_count = r_count + DEPTH_W'(1);
                            end
                        end
                        smao_pkg::ACT_POP: begin
                            if (r_count == '0) begin
                                n_status = smao_pkg::STS_SHORT;
                            end else begin
                                n_count = r_count - DEPTH_W'(1);
                            end
                        end
                        smao_pkg::ACT_DIV, smao_pkg::ACT_MOD: begin
                            if (r_count < DEPTH_W'(2)) begin
                                n_status = smao_pkg::STS_SHORT;
                            end else begin
                                n_state = smao_pkg::ST_RD_TOP;
                            end
                        end
                        smao_pkg::ACT_PCHAR: begin
                            if (r_count == '0) begin
                                n_status = smao_pkg::STS_SHORT;
                            end
                        end
                        smao_pkg::ACT_ROTL: begin
                            if (r_count >= DEPTH_W'(2)) begin
                                n_state = smao_pkg::ST_RD_TOP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            smao_pkg::ST_RD_TOP: begin
                w_re    = 1'b1;
                w_raddr = slot(r_base, r_count - DEPTH_W'(1));
                n_state = (r_action == smao_pkg::ACT_ROTL) ? smao_pkg::ST_ROT
                                                           : smao_pkg::ST_RD_SEC;
            end
            smao_pkg::ST_RD_SEC: begin
                n_dvs   = r_rdata;
                w_re    = 1'b1;
                w_raddr = slot(r_base, r_count - DEPTH_W'(2));
                n_state = smao_pkg::ST_LOAD;
            end
            smao_pkg::ST_LOAD: begin
                if (r_dvs == '0) begin
                    n_status = smao_pkg::STS_DIVZERO;
                    n_state  = smao_pkg::ST_FIN;
                end else begin
                    n_quo   = absval(r_rdata);
                    n_dvs   = absval(r_dvs);
                    n_rem   = '0;
                    n_neg_q = r_rdata[VW-1] ^ r_dvs[VW-1];
                    n_neg_r = r_rdata[VW-1];
                    n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                    n_state = smao_pkg::ST_DIV;
                end
            end
            smao_pkg::ST_DIV: begin
                if (!w_trial[VW+1]) begin
                    n_rem = w_trial[VW-1:0];
                end else begin
                    n_rem = w_shift[VW-1:0];
                end
                n_quo = {r_quo[VW-2:0], ~w_trial[VW+1]};
                if (r_cnt == '0) begin
                    n_state = smao_pkg::ST_WRITE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            smao_pkg::ST_WRITE: begin
                w_we    = 1'b1;
                w_waddr = slot(r_base, r_count - DEPTH_W'(2));
                w_wdata = w_res_neg ? (~w_res_mag + VW'(1)) : w_res_mag;
                n_count = r_count - DEPTH_W'(1);
                n_state = smao_pkg::ST_FIN;
            end
            smao_pkg::ST_ROT: begin
                w_we    = 1'b1;
                w_waddr = w_base_dec;
                w_wdata = r_rdata;
                n_base  = w_base_dec;
                n_state = smao_pkg::ST_FIN;
            end
            smao_pkg::ST_FIN: begin
                // Fetch the new top so the result can report it.
                if (r_count != '0) begin
                    w_re    = 1'b1;
                    w_raddr = slot(r_base, r_count - DEPTH_W'(1));
                end
                n_state = smao_pkg::ST_OUT;
            end
            smao_pkg::ST_OUT: begin
                n_state = smao_pkg::ST_IDLE;
            end
            default: begin
                n_state = smao_pkg::ST_IDLE;
            end
        endcase
    end

    // An unsigned compare against 127 also rejects negative values.
    assign w_char_ok = (r_action == smao_pkg::ACT_PCHAR) && (r_status == smao_pkg::STS_OK)
                       && (r_rdata <= VW'(smao_pkg::CHAR_MAX));

    assign busy         = (r_state != smao_pkg::ST_IDLE);
    assign o_done       = (r_state == smao_pkg::ST_OUT);
    assign o_status     = ((r_action == smao_pkg::ACT_PCHAR) && (r_status == smao_pkg::STS_OK)
                           && !w_char_ok) ? smao_pkg::STS_RANGE : r_status;
    assign o_char_valid = w_char_ok;
    assign o_char_out   = w_char_ok ? r_rdata[smao_pkg::CHAR_W-1:0] : '0;
    assign o_top_value  = (r_count == '0) ? '0 : r_rdata;
    assign o_depth      = r_count;

endmodule

`default_nettype wire
